// ----- hdl/bpa_pkg.sv -----
package bpa_pkg;

  localparam int POOL_DEPTH            = 4096;
  localparam int MAX_PAGES_PER_REQUEST = 16;
  localparam int PAGE_BYTES            = 4096;

  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = POOL_DEPTH / WORD_BITS;
  localparam int WADDR_BITS = $clog2(NUM_WORDS);
  localparam int BIT_BITS   = $clog2(WORD_BITS);
  localparam int IDX_BITS   = $clog2(POOL_DEPTH);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int HIST_BITS  = MAX_PAGES_PER_REQUEST;

  localparam int ADDR_BITS      = 32;
  localparam int POOL_BITS      = 13;
  localparam int COUNT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHYS_BASE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIRT_BASE  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_PAGES = 2'd2;

  localparam logic [ADDR_BITS-1:0] RESET_PHYS_BASE  = 32'h0020_0000;
  localparam logic [ADDR_BITS-1:0] RESET_VIRT_BASE  = 32'hC010_0000;
  localparam logic [POOL_BITS-1:0] RESET_POOL_PAGES = 13'd3840;
  localparam logic [POOL_BITS-1:0] POOL_LIMIT       = POOL_BITS'(POOL_DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic                found;
    logic [BIT_BITS-1:0] pos;
  } run_hit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VSCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_PHYS_RD,
    ST_PHYS_EV,
    ST_FAIL
  } state_t;

endpackage

// ----- hdl/bpa_ram.sv -----
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bpa_run_find.sv -----
module bpa_run_find (
  input  bpa_pkg::word_t                       word,
  input  logic [bpa_pkg::HIST_BITS-1:0]        hist,
  input  logic [bpa_pkg::COUNT_BITS-1:0]       len,
  output bpa_pkg::run_hit_t                    hit
);

  logic [bpa_pkg::WORD_BITS+bpa_pkg::HIST_BITS-1:0] ext;
  logic [bpa_pkg::HIST_BITS-1:0]                    need;
  logic [bpa_pkg::COUNT_BITS:0]                     shamt;
  logic [bpa_pkg::WORD_BITS-1:0]                    ok;

  assign ext   = {word, hist};
  assign shamt = (bpa_pkg::COUNT_BITS+1)'(bpa_pkg::HIST_BITS) - {1'b0, len};
  assign need  = {bpa_pkg::HIST_BITS{1'b1}} << shamt;

  always_comb begin
    for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
      ok[j] = ((ext[j+bpa_pkg::HIST_BITS -: bpa_pkg::HIST_BITS] & need) == '0);
    end
  end

  always_comb begin
    hit.found = |ok;
    hit.pos   = '0;
    for (int j = bpa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (ok[j]) begin
        hit.pos = bpa_pkg::BIT_BITS'(j);
      end
    end
  end

endmodule

// ----- hdl/bitmap_page_allocator.sv -----
// After reset a clearing pass over all 128 words zeroes both bitmaps; no item is taken meanwhile.
// Bad count (zero or above 16): the failure result is loaded once the output slot is free.
// Otherwise the virtual scan reads one 32-bit bitmap word per cycle until a run is found, at
// most all 128 words; marking reads and then writes each touched word, and each physical word
// is read and then evaluated, the evaluation holding while the output slot is full. One item is
// in work at a time. Config resets to defaults.
module bitmap_page_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [bpa_pkg::COUNT_BITS-1:0]      page_count,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [bpa_pkg::ADDR_BITS-1:0]       virt_addr,
  output logic [bpa_pkg::ADDR_BITS-1:0]       phys_addr,
  output logic                                failed,
  output logic                                last,
  input  logic                                cfg_wen,
  input  logic [bpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bpa_pkg::ADDR_BITS-1:0]       cfg_data
);

  bpa_pkg::state_t state, state_next;

  logic [bpa_pkg::ADDR_BITS-1:0]  phys_base, virt_base;
  logic [bpa_pkg::POOL_BITS-1:0]  pool_pages, limit;

  bpa_pkg::word_t                 v_rd, p_rd, v_wdata, p_wdata;
  logic                           v_we, p_we;
  logic [bpa_pkg::WADDR_BITS-1:0] v_waddr, v_raddr, p_waddr;

  logic [bpa_pkg::WADDR_BITS-1:0] clr, vaddr, vdw, mw, pscan, pw;
  logic                           vvalid;
  logic [bpa_pkg::HIST_BITS-1:0]  hist, hist_next;
  logic [bpa_pkg::COUNT_BITS-1:0] len, pages_left;
  logic [bpa_pkg::IDX_BITS-1:0]   vstart, vend, vpage, vend_hit, vstart_hit;

  bpa_pkg::word_t                 v_masked, p_masked, mark_mask, lo_mask, hi_mask, p_bit;
  bpa_pkg::run_hit_t              vhit;
  logic                           p_found, p_end, slot_free, count_bad;
  logic                           load_page, load_fail;
  logic [bpa_pkg::BIT_BITS-1:0]   p_pos;
  logic [bpa_pkg::POOL_BITS-1:0]  next_base;
  logic [bpa_pkg::WADDR_BITS-1:0] sw, ew;
  logic [bpa_pkg::BIT_BITS-1:0]   sb, eb;

  function automatic bpa_pkg::word_t limit_mask(
    input logic [bpa_pkg::WADDR_BITS-1:0] w,
    input logic [bpa_pkg::POOL_BITS-1:0]  lim
  );
    logic [bpa_pkg::POOL_BITS-1:0] lw;
    logic [bpa_pkg::POOL_BITS-1:0] wz;
    lw = lim >> bpa_pkg::BIT_BITS;
    wz = bpa_pkg::POOL_BITS'(w);
    if (lw > wz) begin
      return '0;
    end else if (lw == wz) begin
      return ~bpa_pkg::word_t'(0) << lim[bpa_pkg::BIT_BITS-1:0];
    end else begin
      return '1;
    end
  endfunction

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_BITS),
    .DEPTH (bpa_pkg::NUM_WORDS)
  ) u_virt_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rd)
  );

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_BITS),
    .DEPTH (bpa_pkg::NUM_WORDS)
  ) u_phys_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (pscan),
    .rdata (p_rd)
  );

  bpa_run_find u_run_find (
    .word (v_masked),
    .hist (hist),
    .len  (len),
    .hit  (vhit)
  );

  assign limit     = (pool_pages > bpa_pkg::POOL_LIMIT) ? bpa_pkg::POOL_LIMIT : pool_pages;
  assign slot_free = !rsp_valid || rsp_ready;
  assign count_bad = (page_count == '0) ||
                     (page_count > bpa_pkg::COUNT_BITS'(bpa_pkg::MAX_PAGES_PER_REQUEST));

  assign v_masked   = v_rd | limit_mask(vdw, limit);
  assign hist_next  = v_masked[bpa_pkg::WORD_BITS-1 -: bpa_pkg::HIST_BITS];
  assign vend_hit   = {vdw, vhit.pos};
  assign vstart_hit = vend_hit - bpa_pkg::IDX_BITS'(len) + 1'b1;

  assign sw = vstart[bpa_pkg::IDX_BITS-1 -: bpa_pkg::WADDR_BITS];
  assign sb = vstart[bpa_pkg::BIT_BITS-1:0];
  assign ew = vend[bpa_pkg::IDX_BITS-1 -: bpa_pkg::WADDR_BITS];
  assign eb = vend[bpa_pkg::BIT_BITS-1:0];
  assign lo_mask   = (mw == sw) ? (~bpa_pkg::word_t'(0) << sb) : '1;
  assign hi_mask   = (mw == ew) ?
                     (~bpa_pkg::word_t'(0) >> (bpa_pkg::BIT_BITS'(bpa_pkg::WORD_BITS - 1) - eb)) :
                     '1;
  assign mark_mask = lo_mask & hi_mask;

  assign p_masked  = p_rd | limit_mask(pscan, limit);
  assign p_found   = ~&p_masked;
  assign p_bit     = bpa_pkg::word_t'(1) << p_pos;
  assign next_base = bpa_pkg::POOL_BITS'({(bpa_pkg::WADDR_BITS+1)'(pscan) + 1'b1,
                                          bpa_pkg::BIT_BITS'(0)});
  assign p_end     = (pscan == bpa_pkg::WADDR_BITS'(bpa_pkg::NUM_WORDS - 1)) ||
                     (next_base >= limit);

  always_comb begin
    p_pos = '0;
    for (int j = bpa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (!p_masked[j]) begin
        p_pos = bpa_pkg::BIT_BITS'(j);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::ST_CLEAR: begin
        if (clr == bpa_pkg::WADDR_BITS'(bpa_pkg::NUM_WORDS - 1)) begin
          state_next = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = count_bad ? bpa_pkg::ST_FAIL : bpa_pkg::ST_VSCAN;
        end
      end
      bpa_pkg::ST_VSCAN: begin
        if (vvalid) begin
          if (vhit.found) begin
            state_next = bpa_pkg::ST_MARK_RD;
          end else if (vdw == bpa_pkg::WADDR_BITS'(bpa_pkg::NUM_WORDS - 1)) begin
            state_next = bpa_pkg::ST_FAIL;
          end
        end
      end
      bpa_pkg::ST_MARK_RD: state_next = bpa_pkg::ST_MARK_WR;
      bpa_pkg::ST_MARK_WR: begin
        state_next = (mw == ew) ? bpa_pkg::ST_PHYS_RD : bpa_pkg::ST_MARK_RD;
      end
      bpa_pkg::ST_PHYS_RD: state_next = bpa_pkg::ST_PHYS_EV;
      bpa_pkg::ST_PHYS_EV: begin
        if (p_found) begin
          if (slot_free) begin
            state_next = (pages_left == bpa_pkg::COUNT_BITS'(1)) ?
                         bpa_pkg::ST_IDLE : bpa_pkg::ST_PHYS_RD;
          end
        end else begin
          state_next = p_end ? bpa_pkg::ST_FAIL : bpa_pkg::ST_PHYS_RD;
        end
      end
      bpa_pkg::ST_FAIL: begin
        if (slot_free) begin
          state_next = bpa_pkg::ST_IDLE;
        end
      end
      default: state_next = bpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    v_we      = 1'b0;
    v_waddr   = mw;
    v_wdata   = v_rd | mark_mask;
    v_raddr   = mw;
    p_we      = 1'b0;
    p_waddr   = pscan;
    p_wdata   = p_rd | p_bit;
    load_page = 1'b0;
    load_fail = 1'b0;
    unique case (state)
      bpa_pkg::ST_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr;
        v_wdata = '0;
        p_we    = 1'b1;
        p_waddr = clr;
        p_wdata = '0;
      end
      bpa_pkg::ST_IDLE:    req_ready = 1'b1;
      bpa_pkg::ST_VSCAN:   v_raddr = vaddr;
      bpa_pkg::ST_MARK_WR: v_we = 1'b1;
      bpa_pkg::ST_PHYS_EV: begin
        if (p_found && slot_free) begin
          p_we      = 1'b1;
          load_page = 1'b1;
        end
      end
      bpa_pkg::ST_FAIL:    load_fail = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      pw         <= '0;
      rsp_valid  <= 1'b0;
      phys_base  <= bpa_pkg::RESET_PHYS_BASE;
      virt_base  <= bpa_pkg::RESET_VIRT_BASE;
      pool_pages <= bpa_pkg::RESET_POOL_PAGES;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          bpa_pkg::CFG_PHYS_BASE:  phys_base  <= cfg_data;
          bpa_pkg::CFG_VIRT_BASE:  virt_base  <= cfg_data;
          bpa_pkg::CFG_POOL_PAGES: pool_pages <= cfg_data[bpa_pkg::POOL_BITS-1:0];
          default: ;
        endcase
      end

      case (state)
        bpa_pkg::ST_CLEAR: clr <= clr + 1'b1;
        bpa_pkg::ST_IDLE: begin
          len    <= page_count;
          vaddr  <= '0;
          vvalid <= 1'b0;
          hist   <= '1;
        end
        bpa_pkg::ST_VSCAN: begin
          vaddr  <= vaddr + 1'b1;
          vdw    <= vaddr;
          vvalid <= 1'b1;
          if (vvalid) begin
            if (vhit.found) begin
              vend   <= vend_hit;
              vstart <= vstart_hit;
              vpage  <= vstart_hit;
              mw     <= vstart_hit[bpa_pkg::IDX_BITS-1 -: bpa_pkg::WADDR_BITS];
            end else begin
              hist <= hist_next;
            end
          end
        end
        bpa_pkg::ST_MARK_WR: begin
          mw         <= mw + 1'b1;
          pscan      <= pw;
          pages_left <= len;
        end
        bpa_pkg::ST_PHYS_EV: begin
          if (p_found) begin
            if (slot_free) begin
              pw         <= pscan;
              vpage      <= vpage + 1'b1;
              pages_left <= pages_left - 1'b1;
            end
          end else if (!p_end) begin
            pscan <= pscan + 1'b1;
          end
        end
        default: ;
      endcase

      if (load_page) begin
        rsp_valid <= 1'b1;
        virt_addr <= virt_base + (bpa_pkg::ADDR_BITS'(vpage) << bpa_pkg::PAGE_SHIFT);
        phys_addr <= phys_base +
                     (bpa_pkg::ADDR_BITS'({pscan, p_pos}) << bpa_pkg::PAGE_SHIFT);
        failed    <= 1'b0;
        last      <= (pages_left == bpa_pkg::COUNT_BITS'(1));
      end else if (load_fail) begin
        rsp_valid <= 1'b1;
        virt_addr <= '0;
        phys_addr <= '0;
        failed    <= 1'b1;
        last      <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && failed) |-> (virt_addr == '0 && phys_addr == '0))
    else $error("failure item carries a nonzero address");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::ST_MARK_WR) |-> ((v_rd & mark_mask) == '0))
    else $error("virtual run overlaps used pages");

  a_phys_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::ST_PHYS_EV) |-> (pscan >= pw))
    else $error("physical scan below the full-word pointer");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item taken while one is in work");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_COUNT = (1 << COUNT_BITS) - 1;
  localparam int MAX_POOL  = (1 << POOL_BITS) - 1;
  localparam logic [ADDR_BITS-1:0] TOP_BASE = 32'hFFFF_F000;

  typedef struct packed {
    logic [ADDR_BITS-1:0] virt;
    logic [ADDR_BITS-1:0] phys;
    logic                 failed;
    logic                 last;
  } grant_t;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_PATTERN} rx_style_t;

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  logic [COUNT_BITS-1:0]     page_count;
  logic                      rsp_valid;
  logic                      rsp_ready;
  logic [ADDR_BITS-1:0]      virt_addr;
  logic [ADDR_BITS-1:0]      phys_addr;
  logic                      failed;
  logic                      last;
  logic                      cfg_wen;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [ADDR_BITS-1:0]      cfg_data;

  bitmap_page_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .page_count (page_count),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .failed     (failed),
    .last       (last),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bit [POOL_DEPTH-1:0]  virt_map = '0;
  bit [POOL_DEPTH-1:0]  phys_map = '0;
  int unsigned          virt_taken = 0;
  logic [ADDR_BITS-1:0] shadow_phys_base  = RESET_PHYS_BASE;
  logic [ADDR_BITS-1:0] shadow_virt_base  = RESET_VIRT_BASE;
  logic [POOL_BITS-1:0] shadow_pool_pages = RESET_POOL_PAGES;

  grant_t    grants_due[$];
  int        mismatches = 0;
  rx_style_t rx_style = RX_CHOPPY;
  int        rx_hold_cycles = 0;
  int        rx_tick = 0;
  bit        tx_gaps_on = 1'b1;
  int        tx_burst_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit lowest_clear_run(input bit [POOL_DEPTH-1:0] map,
                                          input int unsigned lim,
                                          input int unsigned len,
                                          output int unsigned at);
    int unsigned run;
    run = 0;
    at = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (map[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == len) begin
          at = i + 1 - len;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_grants(input logic [COUNT_BITS-1:0] cnt);
    int unsigned lim;
    int unsigned vstart;
    int unsigned pidx;
    bit          fits;
    grant_t      g;
    lim = (shadow_pool_pages > POOL_DEPTH) ? POOL_DEPTH : shadow_pool_pages;
    fits = 1'b0;
    if (cnt != 0 && cnt <= MAX_PAGES_PER_REQUEST)
      fits = lowest_clear_run(virt_map, lim, cnt, vstart);
    if (!fits) begin
      grants_due.push_back('{virt: '0, phys: '0, failed: 1'b1, last: 1'b1});
      return;
    end
    for (int unsigned i = 0; i < cnt; i++) virt_map[vstart + i] = 1'b1;
    virt_taken += cnt;
    for (int unsigned i = 0; i < cnt; i++) begin
      if (!lowest_clear_run(phys_map, lim, 1, pidx)) begin
        grants_due.push_back('{virt: '0, phys: '0, failed: 1'b1, last: 1'b1});
        return;
      end
      phys_map[pidx] = 1'b1;
      g.virt   = shadow_virt_base + ADDR_BITS'(vstart + i) * ADDR_BITS'(PAGE_BYTES);
      g.phys   = shadow_phys_base + ADDR_BITS'(pidx) * ADDR_BITS'(PAGE_BYTES);
      g.failed = 1'b0;
      g.last   = (i + 1 == cnt);
      grants_due.push_back(g);
    end
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      if ($urandom_range(0, 1) != 0) return '0;
      return COUNT_BITS'($urandom_range(MAX_PAGES_PER_REQUEST + 1, MAX_COUNT));
    end
    if (roll < 60) return COUNT_BITS'($urandom_range(1, 4));
    return COUNT_BITS'($urandom_range(1, MAX_PAGES_PER_REQUEST));
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_base();
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return '0;
    if (roll == 1) return TOP_BASE;
    return ADDR_BITS'($urandom_range(0, TOP_BASE));
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [ADDR_BITS-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    case (idx)
      CFG_PHYS_BASE:  shadow_phys_base  = data;
      CFG_VIRT_BASE:  shadow_virt_base  = data;
      CFG_POOL_PAGES: shadow_pool_pages = data[POOL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [COUNT_BITS-1:0] cnt);
    @(negedge clk);
    req_valid  <= 1'b1;
    page_count <= cnt;
    do @(posedge clk); while (!req_ready);
    predict_grants(cnt);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic offer(input logic [COUNT_BITS-1:0] cnt);
    if (tx_gaps_on && tx_burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(60, 300));
      else pause_sender($urandom_range(1, 30));
      tx_burst_left = $urandom_range(1, 6);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    send_request(cnt);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    offer(5'd1);
    offer(COUNT_BITS'(MAX_PAGES_PER_REQUEST));
    offer('0);
    offer(COUNT_BITS'(MAX_PAGES_PER_REQUEST + 1));
    offer(COUNT_BITS'(MAX_COUNT));
    offer(5'd2);
    offer(5'd15);
    offer(5'd7);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_PHYS_BASE, '0);
    write_reg(CFG_VIRT_BASE, TOP_BASE);
    offer(5'd1);
    offer(5'd3);
    wait_drained();
    write_reg(CFG_PHYS_BASE, TOP_BASE);
    write_reg(CFG_VIRT_BASE, '0);
    // oversized pool, with junk above the register width
    write_reg(CFG_POOL_PAGES, {19'($urandom), POOL_BITS'(MAX_POOL)});
    offer(COUNT_BITS'(MAX_PAGES_PER_REQUEST));
    offer(5'd2);
    wait_drained();
    write_reg(CFG_UNUSED, $urandom);
    offer(5'd1);
    wait_drained();
    write_reg(CFG_POOL_PAGES, ADDR_BITS'(POOL_DEPTH));
    offer(5'd4);
    wait_drained();
  endtask

  task automatic test_no_virtual_run();
    write_reg(CFG_POOL_PAGES, ADDR_BITS'(virt_taken + 5));
    offer(5'd4);
    offer(5'd4);
    offer(5'd1);
    offer(5'd1);
    wait_drained();
    write_reg(CFG_POOL_PAGES, ADDR_BITS'(virt_taken));
    offer(5'd1);
    wait_drained();
    write_reg(CFG_POOL_PAGES, '0);
    offer(5'd1);
    offer(COUNT_BITS'(MAX_PAGES_PER_REQUEST));
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_POOL_PAGES, ADDR_BITS'(RESET_POOL_PAGES));
    tx_gaps_on = 1'b0;
    rx_style = RX_OPEN;
    rx_hold_cycles = 400;
    repeat (6) offer(pick_count());
    repeat (4) offer(pick_count());
    wait_drained();
    rx_style = RX_PATTERN;
    repeat (4) offer(pick_count());
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned roll;
    logic [ADDR_BITS-1:0] pool;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_PHYS_BASE, pick_base());
      write_reg(CFG_VIRT_BASE, pick_base());
      roll = $urandom_range(0, 9);
      if (roll < 5) pool = virt_taken + $urandom_range(0, 40);
      else if (roll < 7) pool = POOL_DEPTH;
      else if (roll < 8) pool = $urandom_range(POOL_DEPTH + 1, MAX_POOL);
      else pool = $urandom_range(virt_taken, RESET_POOL_PAGES);
      write_reg(CFG_POOL_PAGES, pool);
      tx_gaps_on = (phase != 0);
      rx_style = rx_style_t'($urandom_range(0, 2));
      repeat (13) offer(pick_count());
      wait_drained();
    end
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        rsp_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:    rsp_ready <= 1'b1;
          RX_CHOPPY:  rsp_ready <= ($urandom_range(0, 99) < 60);
          default:    rsp_ready <= ((rx_tick / 3) % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_grants
    grant_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result virt_addr=%h phys_addr=%h failed=%b last=%b",
                 $time, virt_addr, phys_addr, failed, last);
        mismatches++;
      end else begin
        want = grants_due.pop_front();
        if (virt_addr !== want.virt) begin
          $display("%0t: virt_addr expected %h actual %h", $time, want.virt, virt_addr);
          mismatches++;
        end
        if (phys_addr !== want.phys) begin
          $display("%0t: phys_addr expected %h actual %h", $time, want.phys, phys_addr);
          mismatches++;
        end
        if (failed !== want.failed) begin
          $display("%0t: failed expected %b actual %b", $time, want.failed, failed);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    page_count = '0;
    cfg_wen    = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_config_extremes();
    test_no_virtual_run();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_run_find.sv
hdl/bitmap_page_allocator.sv
tb/testbench.sv
